// File: design/rfdd_pkg.sv
`default_nettype none

package rfdd_pkg;

   localparam int PAYLOAD_DEPTH = 16;
   localparam int CHANNEL_COUNT = 10;
   localparam int PD_IDX_W      = $clog2(PAYLOAD_DEPTH);
   localparam int CNT_W         = 5;
   localparam int RC_BYTES      = 9;
   localparam int HEALTH_BYTES  = 6;
   // x / 1000 == (x * MS_RECIP) >> MS_SHIFT for every 32-bit x
   localparam logic [28:0] MS_RECIP = 29'h10624DD3;
   localparam int MS_SHIFT      = 38;
   localparam int CH_OFFSET     = 1000;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] KIND_RC     = 3'd0;
   localparam logic [2:0] KIND_HEALTH = 3'd1;
   localparam logic [2:0] KIND_PING   = 3'd2;
   localparam logic [2:0] KIND_PONG   = 3'd3;
   localparam logic [2:0] KIND_OTHER  = 3'd4;
   localparam logic [2:0] KIND_ERR    = 3'd5;

   localparam logic [2:0] CSR_LINK_ID     = 3'd0;
   localparam logic [2:0] CSR_RC_TYPE     = 3'd1;
   localparam logic [2:0] CSR_HEALTH_TYPE = 3'd2;
   localparam logic [2:0] CSR_PING_TYPE   = 3'd3;
   localparam logic [2:0] CSR_PONG_TYPE   = 3'd4;

   typedef struct packed {
      logic [7:0] link_id;
      logic [3:0] rc_type;
      logic [3:0] health_type;
      logic [3:0] ping_type;
      logic [3:0] pong_type;
   } cfg_type;

   // one decoded frame handed from the front to the back
   typedef struct packed {
      logic [2:0]                kind;
      logic [3:0]                frame_type;
      logic [RC_BYTES-1:0][7:0]  payload;
      logic [31:0]               delta;
   } job_type;

   typedef logic [9:0] scale8_tab_type [256];
   typedef logic [9:0] scale4_tab_type [16];

   function automatic scale8_tab_type build_scale8();
      scale8_tab_type t;
      for (int i = 0; i < 256; i++) begin
         t[i] = 10'((i * 1000) / 255);
      end
      return t;
   endfunction

   function automatic scale4_tab_type build_scale4();
      scale4_tab_type t;
      for (int i = 0; i < 16; i++) begin
         t[i] = 10'((i * 1000) / 15);
      end
      return t;
   endfunction

   localparam scale8_tab_type SCALE8_TAB = build_scale8();
   localparam scale4_tab_type SCALE4_TAB = build_scale4();

   // unpack and scale one RC channel, 1000..2023
   function automatic logic [10:0] rc_channel(logic [RC_BYTES-1:0][7:0] p, logic [3:0] idx);
      logic [9:0] scaled;
      unique case (idx)
         4'd0:    scaled = {p[0], p[1][7:6]};
         4'd1:    scaled = {p[1][5:0], p[2][7:4]};
         4'd2:    scaled = {p[2][3:0], p[3][7:2]};
         4'd3:    scaled = {p[3][1:0], p[4]};
         4'd4:    scaled = SCALE8_TAB[p[5]];
         4'd5:    scaled = SCALE8_TAB[p[6]];
         4'd6:    scaled = SCALE4_TAB[p[7][7:4]];
         4'd7:    scaled = SCALE4_TAB[p[7][3:0]];
         4'd8:    scaled = SCALE4_TAB[p[8][7:4]];
         4'd9:    scaled = SCALE4_TAB[p[8][3:0]];
         default: scaled = '0;
      endcase
      return 11'(scaled) + 11'(CH_OFFSET);
   endfunction

endpackage

`default_nettype wire

// File: design/rfdd_front.sv
`default_nettype none

module rfdd_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire rfdd_pkg::cfg_type  cfg,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [7:0]         req_rx_byte,
   input  wire logic [31:0]        req_now_us,
   input  wire logic               q_full,
   output logic                    q_push,
   output rfdd_pkg::job_type       q_job
);

   localparam logic [1:0] PH_HUNT    = 2'd0;
   localparam logic [1:0] PH_HEADER  = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;
   localparam logic [1:0] PH_CHECK   = 2'd3;

   logic [1:0]                  phase_ff, phase_in;
   logic [7:0]                  xor_ff, xor_in;
   logic [3:0]                  type_ff, type_in;
   logic [3:0]                  len_ff, len_in;
   logic [rfdd_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [7:0]                  store_ff [rfdd_pkg::PAYLOAD_DEPTH];
   logic                        store_we;
   logic                        accept;
   logic [rfdd_pkg::RC_BYTES-1:0][7:0] rd;
   logic [31:0]                 stamp;
   logic [rfdd_pkg::CNT_W-1:0]  count_inc;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign count_inc = count_ff + rfdd_pkg::CNT_W'(1);

   // bytes past the fill count read as zero
   always_comb begin
      for (int i = 0; i < rfdd_pkg::RC_BYTES; i++) begin
         rd[i] = (rfdd_pkg::CNT_W'(i) < count_ff) ? store_ff[i] : 8'h00;
      end
   end

   assign stamp = {rd[3], rd[2], rd[1], rd[0]};

   always_comb begin
      q_job.payload    = rd;
      q_job.frame_type = type_ff;
      q_job.delta      = req_now_us - stamp;
      priority if (xor_ff != req_rx_byte) q_job.kind = rfdd_pkg::KIND_ERR;
      else if (type_ff == cfg.rc_type)     q_job.kind = rfdd_pkg::KIND_RC;
      else if (type_ff == cfg.health_type) q_job.kind = rfdd_pkg::KIND_HEALTH;
      else if (type_ff == cfg.ping_type)   q_job.kind = rfdd_pkg::KIND_PING;
      else if (type_ff == cfg.pong_type)   q_job.kind = rfdd_pkg::KIND_PONG;
      else                                 q_job.kind = rfdd_pkg::KIND_OTHER;
   end

   always_comb begin
      phase_in = phase_ff;
      xor_in   = xor_ff;
      type_in  = type_ff;
      len_in   = len_ff;
      count_in = count_ff;
      store_we = 1'b0;
      q_push   = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (req_rx_byte == cfg.link_id) begin
                  phase_in = PH_HEADER;
                  xor_in   = req_rx_byte;
                  count_in = '0;
               end
            end
            PH_HEADER: begin
               xor_in   = xor_ff ^ req_rx_byte;
               type_in  = req_rx_byte[7:4];
               len_in   = req_rx_byte[3:0];
               phase_in = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               if (count_ff >= rfdd_pkg::CNT_W'(rfdd_pkg::PAYLOAD_DEPTH)) begin
                  phase_in = PH_HUNT;   // overflow: drop byte, abort frame
               end else begin
                  xor_in   = xor_ff ^ req_rx_byte;
                  store_we = 1'b1;
                  count_in = count_inc;
                  if (count_inc == rfdd_pkg::CNT_W'(len_ff)) begin
                     phase_in = PH_CHECK;
                  end
               end
            end
            PH_CHECK: begin
               q_push   = 1'b1;
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         xor_ff   <= '0;
         type_ff  <= '0;
         len_ff   <= '0;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         xor_ff   <= xor_in;
         type_ff  <= type_in;
         len_ff   <= len_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[count_ff[rfdd_pkg::PD_IDX_W-1:0]] <= req_rx_byte;
      end
   end

endmodule

`default_nettype wire

// File: design/rfdd_queue.sv
`default_nettype none

module rfdd_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire rfdd_pkg::job_type  push_job,
   output logic                    full,
   input  wire logic               pop,
   output rfdd_pkg::job_type       head_job,
   output logic                    empty
);

   rfdd_pkg::job_type            mem_ff [rfdd_pkg::QUEUE_DEPTH];
   logic [rfdd_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [rfdd_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [rfdd_pkg::QCNT_W-1:0]  cnt_ff, cnt_in;
   logic                         do_push, do_pop;

   assign full     = cnt_ff == rfdd_pkg::QCNT_W'(rfdd_pkg::QUEUE_DEPTH);
   assign empty    = cnt_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == rfdd_pkg::QPTR_W'(rfdd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + rfdd_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == rfdd_pkg::QPTR_W'(rfdd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + rfdd_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + rfdd_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - rfdd_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// File: design/rfdd_back.sv
`default_nettype none

module rfdd_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_empty,
   input  wire rfdd_pkg::job_type  q_job,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [2:0]              rsp_kind,
   output logic [3:0]              rsp_item_index,
   output logic [22:0]             rsp_item_value,
   output logic [3:0]              rsp_frame_type,
   output logic                    rsp_last_of_run
);

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_DIV  = 2'd1;
   localparam logic [1:0] B_EMIT = 2'd2;

   logic [1:0]            state_ff, state_in;
   rfdd_pkg::job_type     job_ff, job_in;
   logic [3:0]            idx_ff, idx_in;
   logic [31:0]           quo_ff, quo_in;

   logic                  valid_ff, valid_in;
   logic [2:0]            kind_ff;
   logic [3:0]            index_ff;
   logic [22:0]           value_ff;
   logic [3:0]            ftype_ff;
   logic                  last_ff;

   logic                  out_free, load;
   logic                  is_last;
   logic [22:0]           value;
   logic [7:0]            health_byte;
   logic [60:0]           prod;

   assign out_free = !valid_ff || !rsp_stall;

   // divide by 1000 as a reciprocal multiply
   assign prod = 61'(quo_ff) * 61'(rfdd_pkg::MS_RECIP);

   always_comb begin
      unique case (idx_ff)
         4'd0:    health_byte = job_ff.payload[0];
         4'd1:    health_byte = job_ff.payload[1];
         4'd2:    health_byte = job_ff.payload[2];
         4'd3:    health_byte = job_ff.payload[3];
         4'd4:    health_byte = job_ff.payload[4];
         4'd5:    health_byte = job_ff.payload[5];
         default: health_byte = 8'h00;
      endcase
   end

   always_comb begin
      unique case (job_ff.kind)
         rfdd_pkg::KIND_RC: begin
            value   = 23'(rfdd_pkg::rc_channel(job_ff.payload, idx_ff));
            is_last = idx_ff == 4'(rfdd_pkg::CHANNEL_COUNT - 1);
         end
         rfdd_pkg::KIND_HEALTH: begin
            value   = 23'(health_byte);
            is_last = idx_ff == 4'(rfdd_pkg::HEALTH_BYTES - 1);
         end
         rfdd_pkg::KIND_PONG: begin
            value   = quo_ff[22:0];
            is_last = 1'b1;
         end
         default: begin
            value   = '0;
            is_last = 1'b1;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      idx_in   = idx_ff;
      quo_in   = quo_ff;
      q_pop    = 1'b0;
      load     = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               job_in = q_job;
               idx_in = '0;
               if (q_job.kind == rfdd_pkg::KIND_PONG) begin
                  state_in = B_DIV;
                  quo_in   = q_job.delta;
               end else begin
                  state_in = B_EMIT;
               end
            end
         end
         B_DIV: begin
            quo_in   = 32'(prod >> rfdd_pkg::MS_SHIFT);
            state_in = B_EMIT;
         end
         B_EMIT: begin
            if (out_free) begin
               load = 1'b1;
               if (is_last) begin
                  state_in = B_IDLE;
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      idx_ff  <= idx_in;
      quo_ff  <= quo_in;
      if (load) begin
         kind_ff  <= job_ff.kind;
         index_ff <= idx_ff;
         value_ff <= value;
         ftype_ff <= job_ff.frame_type;
         last_ff  <= is_last;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_item_index  = index_ff;
   assign rsp_item_value  = value_ff;
   assign rsp_frame_type  = ftype_ff;
   assign rsp_last_of_run = last_ff;

endmodule

`default_nettype wire

// File: design/radio_frame_deframer_decoder_core.sv
// Radio frame deframer and decoder.
// req_*: one received byte and the microsecond time per word. csr_*: five
// registers (channel byte, RC / health / ping / pong type codes); the user
// must write them only while the block is idle, the block does not enforce it.
// rsp_*: decoded results, one per word; last_of_run marks the final
// result of a frame. RC frames give ten words, health frames six, ping,
// pong, unknown type and checksum error one each.
// Input: one byte per cycle while req_stall is low. The front parser hands
// each finished frame to a two-entry queue; it stalls the input only while
// that queue is full. The back end pops a frame into its job register, then
// loads the output register and raises rsp_valid; it then gives one word a
// cycle while rsp_stall is low, going through idle between frames. Pong
// frames add a back-end divide state for the divide by 1000 (a reciprocal
// multiply). A stalled result is held in the output register; the back end
// waits and the queue fills, after which req_stall rises.
// Reset (synchronous) returns the parser to hunting for the channel byte,
// empties the queue and loads the register reset values. No clearing pass:
// the payload store is tracked by its fill count.
`default_nettype none

module radio_frame_deframer_decoder_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic [31:0] req_now_us,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_kind,
   output logic [3:0]       rsp_item_index,
   output logic [22:0]      rsp_item_value,
   output logic [3:0]       rsp_frame_type,
   output logic             rsp_last_of_run,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [7:0]  csr_wr_data
);

   rfdd_pkg::cfg_type  cfg_ff;
   rfdd_pkg::job_type  push_job, head_job;
   logic               q_push, q_full, q_pop, q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.link_id     <= 8'd0;
         cfg_ff.rc_type     <= 4'd0;
         cfg_ff.health_type <= 4'd1;
         cfg_ff.ping_type   <= 4'd2;
         cfg_ff.pong_type   <= 4'd3;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            rfdd_pkg::CSR_LINK_ID:     cfg_ff.link_id     <= csr_wr_data;
            rfdd_pkg::CSR_RC_TYPE:     cfg_ff.rc_type     <= csr_wr_data[3:0];
            rfdd_pkg::CSR_HEALTH_TYPE: cfg_ff.health_type <= csr_wr_data[3:0];
            rfdd_pkg::CSR_PING_TYPE:   cfg_ff.ping_type   <= csr_wr_data[3:0];
            rfdd_pkg::CSR_PONG_TYPE:   cfg_ff.pong_type   <= csr_wr_data[3:0];
            default: ;
         endcase
      end
   end

   rfdd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .req_now_us  (req_now_us),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_job       (push_job)
   );

   rfdd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .head_job (head_job),
      .empty    (q_empty)
   );

   rfdd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_job           (head_job),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_item_index  (rsp_item_index),
      .rsp_item_value  (rsp_item_value),
      .rsp_frame_type  (rsp_frame_type),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire

// File: design/rfdd_checker.sv
`default_nettype none

module rfdd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [2:0]  rsp_kind,
   input wire logic [3:0]  rsp_item_index,
   input wire logic [22:0] rsp_item_value,
   input wire logic [3:0]  rsp_frame_type,
   input wire logic        rsp_last_of_run
);

   // a held result word must not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_item_index) && $stable(rsp_item_value) &&
      $stable(rsp_frame_type) && $stable(rsp_last_of_run))
      else $error("result word changed while stalled");

   a_rc_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == rfdd_pkg::KIND_RC |->
      rsp_item_value >= 23'd1000 && rsp_item_value <= 23'd2023)
      else $error("rc channel out of range");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != rfdd_pkg::KIND_RC &&
      rsp_kind != rfdd_pkg::KIND_HEALTH |-> rsp_last_of_run && rsp_item_index == 4'd0)
      else $error("single-word result not marked last");

   // channel words come out in order within a frame
   a_rc_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_kind == rfdd_pkg::KIND_RC && !rsp_last_of_run
      |=> !rsp_valid || (rsp_kind == rfdd_pkg::KIND_RC &&
      rsp_item_index == $past(rsp_item_index) + 4'd1))
      else $error("rc channel order broken");

endmodule

bind radio_frame_deframer_decoder_core rfdd_checker u_rfdd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_kind        (rsp_kind),
   .rsp_item_index  (rsp_item_index),
   .rsp_item_value  (rsp_item_value),
   .rsp_frame_type  (rsp_frame_type),
   .rsp_last_of_run (rsp_last_of_run)
);

`default_nettype wire
